[sv/tsf_pkg.sv]
// ----------------------------------------------------------------------------
// tsf_pkg
// shared constants and the deletion test for the thinning sub-pass filter
// ----------------------------------------------------------------------------
package tsf_pkg;

  localparam int DEF_MAX_WIDTH = 1024;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IMG_W_BITS = 11;
  localparam int IMG_H_BITS = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SUB_PASS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [IMG_W_BITS-1:0] RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [IMG_H_BITS-1:0] RST_IMAGE_HEIGHT = 16'd1024;
  localparam int                    MIN_DIM          = 3;

  // input commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // window: column oldest/middle/newest at bits 0/3/6, top row +0, bottom +2
  function automatic logic judge_delete(input logic [8:0] win, input logic pass_sel);
    logic [7:0] p;
    logic [3:0] trans;
    logic [3:0] count;
    logic       m1;
    logic       m2;
    p = {win[0], win[1], win[2], win[5], win[8], win[7], win[6], win[3]};
    trans = '0;
    count = '0;
    for (int i = 0; i < 8; i++) begin
      if (!p[i] && p[(i + 1) % 8]) begin
        trans = trans + 4'd1;
      end
      count = count + {3'd0, p[i]};
    end
    // p2=p[0] p4=p[2] p6=p[4] p8=p[6]
    if (!pass_sel) begin
      m1 = p[0] & p[2] & p[4];
      m2 = p[2] & p[4] & p[6];
    end else begin
      m1 = p[0] & p[2] & p[6];
      m2 = p[0] & p[4] & p[6];
    end
    return win[4] && (trans == 4'd1) && (count >= 4'd2) && (count <= 4'd6) && !m1 && !m2;
  endfunction

endpackage

[sv/thinning_subpass_filter.sv]
// a result is shown from the output register, after the stage 1 register, once its item is
// transferred; the result for a pixel comes with the item image_width+1 places later
// in the stream; throughput: one item per cycle while the output is not held, set by the
// single line-buffer ram (one read, one write); reset: synchronous, clears counters, window,
// pipeline and output valid; the line buffer is not cleared and needs no pass after reset
// ----------------------------------------------------------------------------
// thinning_subpass_filter
// one zhang-suen sub-pass over a raster-order binary frame, two-line buffer in ram
// ----------------------------------------------------------------------------
module thinning_subpass_filter import tsf_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  command,
  input  logic                  pixel_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  pixel_out,
  output logic                  deleted,
  output logic                  last_of_frame,
  output logic                  frame_had_deletion
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW = (CW + 1 > IMG_W_BITS) ? CW + 1 : IMG_W_BITS;
  localparam int HW = IMG_H_BITS + 1;
  localparam logic [EW-1:0] MAX_W = EW'(MAX_WIDTH);

  // configuration
  logic                  sub_pass;
  logic [IMG_W_BITS-1:0] image_width;
  logic [IMG_H_BITS-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_pass     <= 1'b0;
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SUB_PASS:     sub_pass     <= cfg_data[0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [EW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  always_comb begin
    if (EW'(image_width) < EW'(MIN_DIM)) begin
      eff_w = EW'(MIN_DIM);
    end else if (EW'(image_width) > MAX_W) begin
      eff_w = MAX_W;
    end else begin
      eff_w = EW'(image_width);
    end
    if (image_height < IMG_H_BITS'(MIN_DIM)) begin
      eff_h = HW'(MIN_DIM);
    end else begin
      eff_h = {1'b0, image_height};
    end
  end

  // stage 0: position counters, ram read issued on transfer
  logic [CW-1:0]         in_column;
  logic                  row_started;
  logic                  emitting;
  logic [IMG_H_BITS-1:0] out_row;
  logic [CW-1:0]         out_col;

  logic          accept;
  logic          advance;
  logic          pix;
  logic          col_wrap;
  logic          emit;
  logic          out_col_wrap;
  logic          last;
  logic          interior;
  logic [HW-1:0] row_x;

  assign accept = in_valid && in_ready;
  assign pix    = (command == CMD_PIXEL) ? pixel_in : 1'b0;

  always_comb begin
    row_x        = {1'b0, out_row};
    col_wrap     = (EW'(in_column) + EW'(1)) >= eff_w;
    emit         = emitting || (row_started && (in_column != '0));
    out_col_wrap = (EW'(out_col) + EW'(1)) >= eff_w;
    last         = (row_x >= eff_h) || (((row_x + HW'(1)) >= eff_h) && out_col_wrap);
    interior     = (out_row != '0) && ((row_x + HW'(2)) <= eff_h) &&
                   (out_col != '0) && ((EW'(out_col) + EW'(2)) <= eff_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column   <= '0;
      row_started <= 1'b0;
      emitting    <= 1'b0;
      out_row     <= '0;
      out_col     <= '0;
    end else if (accept) begin
      if (emit && last) begin
        in_column   <= '0;
        row_started <= 1'b0;
        emitting    <= 1'b0;
        out_row     <= '0;
        out_col     <= '0;
      end else begin
        in_column <= col_wrap ? '0 : in_column + CW'(1);
        if (col_wrap) begin
          row_started <= 1'b1;
        end
        emitting <= emit;
        if (emit) begin
          if (out_col_wrap) begin
            out_col <= '0;
            out_row <= out_row + IMG_H_BITS'(1);
          end else begin
            out_col <= out_col + CW'(1);
          end
        end
      end
    end
  end

  // stage 1: ram data back, window shift, judgement, write back
  logic          s1_valid;
  logic          s1_emit;
  logic          s1_interior;
  logic          s1_last;
  logic          s1_pix;
  logic [CW-1:0] s1_col;
  logic          s1_fwd;
  logic [1:0]    s1_fwd_data;

  logic [1:0] ram_rdata;
  logic [1:0] line_bits;
  logic [8:0] window;
  logic [8:0] window_next;
  logic       del;
  logic       any_deleted;

  // line entry is {middle, upper}
  assign line_bits   = s1_fwd ? s1_fwd_data : ram_rdata;
  assign window_next = {s1_pix, line_bits[1], line_bits[0], window[8:3]};
  assign del         = s1_interior && judge_delete(window_next, sub_pass);

  assign advance  = s1_valid && (!s1_emit || !out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  tsf_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (advance),
    .wr_addr (s1_col),
    .wr_data ({s1_pix, line_bits[1]}),
    .rd_en   (accept),
    .rd_addr (in_column),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit     <= emit;
      s1_interior <= interior;
      s1_last     <= last;
      s1_pix      <= pix;
      s1_col      <= in_column;
      // same column written this cycle, e.g. first column after a frame end
      s1_fwd      <= advance && (in_column == s1_col);
      s1_fwd_data <= {s1_pix, line_bits[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window      <= '0;
      any_deleted <= 1'b0;
    end else if (advance) begin
      window <= (s1_emit && s1_last) ? '0 : window_next;
      if (s1_emit) begin
        any_deleted <= s1_last ? 1'b0 : (any_deleted | del);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_emit) begin
      pixel_out          <= window_next[4] & ~del;
      deleted            <= del;
      last_of_frame      <= s1_last;
      frame_had_deletion <= s1_last & (any_deleted | del);
    end
  end

endmodule

[sv/tsf_ram.sv]
// ----------------------------------------------------------------------------
// tsf_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tsf_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/tsf_checker.sv]
// ----------------------------------------------------------------------------
// tsf_checker
// port-level checks on the result channel of the thinning sub-pass filter
// ----------------------------------------------------------------------------
module tsf_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic pixel_out,
  input logic deleted,
  input logic last_of_frame,
  input logic frame_had_deletion
);

  // stalled transfer keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(deleted) &&
      $stable(last_of_frame) && $stable(frame_had_deletion))
    else $error("result changed while stalled");

  // a removed pixel leaves background behind
  a_del_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && deleted |-> !pixel_out)
    else $error("deleted pixel still set");

  // frame summary only on the closing pixel
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_had_deletion |-> last_of_frame)
    else $error("frame summary outside last pixel");

  // a deletion on the closing pixel must show in the summary
  a_summary_self: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_frame && deleted |-> frame_had_deletion)
    else $error("summary misses deletion on last pixel");

  // nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind thinning_subpass_filter tsf_checker u_tsf_checker (.*);
